FILE: rtl/assert_macros.svh
// Assertion macros used by the verification checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define GHA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a consequence holds in the cycle after an antecedent.
`define GHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gha_pkg.sv
// Types and codes shared by the generational handle allocator files.
package gha_pkg;

    localparam int HANDLE_W = 32;

    // Request action codes
    localparam logic [1:0] ACT_CREATE  = 2'd0;
    localparam logic [1:0] ACT_DESTROY = 2'd1;
    localparam logic [1:0] ACT_CHECK   = 2'd2;

    // Response status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic ready;
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/gha_if.sv
// Request and response channel interfaces of the handle allocator.
interface gha_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] handle_in;

    modport source (output valid, output action, output handle_in, input ready);
    modport sink (input valid, input action, input handle_in, output ready);
endinterface

interface gha_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] handle_out;
    logic [1:0]  status;

    modport source (output valid, output handle_out, output status, input ready);
    modport sink (input valid, input handle_out, input status, output ready);
endinterface

FILE: rtl/gha_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        // hold read data until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/gha_ctrl.sv
// Controller state machine: read phase, then commit phase of each request.
module gha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  gha_pkg::dp_stat_t  stat,
    output gha_pkg::ctrl_cmd_t cmd
);

    gha_pkg::state_t state_reg;
    gha_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gha_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gha_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = gha_pkg::ST_EXEC;
                end
            end
            gha_pkg::ST_EXEC:
            begin
                // stay until the result register can take the answer
                if (stat.out_free)
                begin
                    state_next = gha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gha_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            gha_pkg::ST_IDLE:
            begin
                cmd.ready   = 1'b1;
                cmd.capture = req_valid;
            end
            gha_pkg::ST_EXEC:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/gha_datapath.sv
// Datapath: version table, free stack, counters and result register.
module gha_datapath #(
    parameter int INDEX_BITS   = 10,
    parameter int VERSION_BITS = 22
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gha_pkg::ctrl_cmd_t cmd,
    output gha_pkg::dp_stat_t  stat,
    input  logic [1:0]         req_action,
    input  logic [31:0]        req_handle,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [31:0]        out_handle,
    output logic [1:0]         out_status
);

    localparam int SLOTS = 1 << INDEX_BITS;
    localparam int TBL_W = VERSION_BITS + 1;

    logic [1:0]              act_reg;
    logic [31:0]             hdl_reg;
    logic [INDEX_BITS:0]     free_cnt_reg;
    logic [INDEX_BITS:0]     free_cnt_next;
    logic [INDEX_BITS:0]     mark_reg;
    logic [INDEX_BITS:0]     mark_next;
    logic [VERSION_BITS-1:0] ver_reg;
    logic [VERSION_BITS-1:0] ver_next;
    logic                    out_valid_reg;
    logic [31:0]             hout_reg;
    logic [31:0]             hout_next;
    logic [1:0]              status_reg;
    logic [1:0]              status_next;

    logic [INDEX_BITS:0]              cnt_dec;
    logic [INDEX_BITS-1:0]            stk_rd;
    logic [TBL_W-1:0]                 tbl_rd;
    logic [INDEX_BITS-1:0]            idx_h;
    logic [VERSION_BITS+31:0]         hdl_ext;
    logic [VERSION_BITS-1:0]          ver_h;
    logic [TBL_W-1:0]                 ver_h_p1;
    logic                             live;
    logic                             stack_has;
    logic                             got;
    logic [INDEX_BITS-1:0]            new_idx;
    logic [INDEX_BITS+VERSION_BITS+31:0] packed_h;
    logic                             tbl_we;
    logic [INDEX_BITS-1:0]            tbl_wa;
    logic [TBL_W-1:0]                 tbl_wd;
    logic                             stk_we;

    // Capture the request; memory reads are issued in the same cycle
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= req_action;
            hdl_reg <= req_handle;
        end
        if (cmd.commit)
        begin
            hout_reg   <= hout_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_cnt_reg  <= '0;
            mark_reg      <= '0;
            ver_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            free_cnt_reg <= free_cnt_next;
            mark_reg     <= mark_next;
            ver_reg      <= ver_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cnt_dec = free_cnt_reg - 1'b1;

    gha_ram #(
        .WIDTH (INDEX_BITS),
        .DEPTH (SLOTS)
    ) u_stack (
        .clk     (clk),
        .we      (stk_we),
        .wr_addr (free_cnt_reg[INDEX_BITS-1:0]),
        .wr_data (idx_h),
        .rd_en   (cmd.capture),
        .rd_addr (cnt_dec[INDEX_BITS-1:0]),
        .rd_data (stk_rd)
    );

    gha_ram #(
        .WIDTH (TBL_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk     (clk),
        .we      (tbl_we),
        .wr_addr (tbl_wa),
        .wr_data (tbl_wd),
        .rd_en   (cmd.capture),
        .rd_addr (req_handle[INDEX_BITS-1:0]),
        .rd_data (tbl_rd)
    );

    // Liveness of the captured handle
    assign idx_h    = hdl_reg[INDEX_BITS-1:0];
    assign hdl_ext  = {{VERSION_BITS{1'b0}}, hdl_reg};
    assign ver_h    = hdl_ext[INDEX_BITS +: VERSION_BITS];
    assign ver_h_p1 = {1'b0, ver_h} + 1'b1;
    assign live     = (hdl_reg != '1) && ({1'b0, idx_h} < mark_reg) && (tbl_rd == ver_h_p1);

    // Slot choice for create: top of free stack, else the next fresh slot
    assign stack_has = (free_cnt_reg != '0);
    assign got       = stack_has || !mark_reg[INDEX_BITS];
    assign new_idx   = stack_has ? stk_rd : mark_reg[INDEX_BITS-1:0];
    assign packed_h  = {32'b0, ver_reg, new_idx};

    always_comb
    begin
        free_cnt_next = free_cnt_reg;
        mark_next     = mark_reg;
        ver_next      = ver_reg;
        hout_next     = '0;
        status_next   = gha_pkg::STAT_BAD;
        tbl_we        = 1'b0;
        tbl_wa        = idx_h;
        tbl_wd        = '0;
        stk_we        = 1'b0;
        case (act_reg)
            gha_pkg::ACT_CREATE:
            begin
                tbl_wa = new_idx;
                tbl_wd = {1'b0, ver_reg} + 1'b1;
                if (got)
                begin
                    hout_next   = packed_h[31:0];
                    status_next = gha_pkg::STAT_OK;
                    tbl_we      = cmd.commit;
                    if (cmd.commit)
                    begin
                        ver_next = ver_reg + 1'b1;
                        if (stack_has)
                        begin
                            free_cnt_next = cnt_dec;
                        end
                        else
                        begin
                            mark_next = mark_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    status_next = gha_pkg::STAT_FULL;
                end
            end
            gha_pkg::ACT_DESTROY:
            begin
                if (live)
                begin
                    status_next = gha_pkg::STAT_OK;
                    tbl_we      = cmd.commit;
                    stk_we      = cmd.commit && !free_cnt_reg[INDEX_BITS];
                    if (stk_we)
                    begin
                        free_cnt_next = free_cnt_reg + 1'b1;
                    end
                end
            end
            gha_pkg::ACT_CHECK:
            begin
                status_next = live ? gha_pkg::STAT_OK : gha_pkg::STAT_BAD;
            end
            default:
            begin
                status_next = gha_pkg::STAT_BAD;
            end
        endcase
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_handle    = hout_reg;
    assign out_status    = status_reg;

endmodule

FILE: rtl/generational_handle_allocator.sv
// Top level of the generational handle allocator.
//
// Each request passes through two states: in IDLE the request is captured
// and the version table and free stack are read; in EXEC the answer is
// formed, the memories are written and the response register is loaded.
// Both memories have one write port and one registered read port, so the
// read and the write of a request fall in different cycles and nothing
// needs forwarding. A new request is taken while the previous response
// still waits in its register; the commit cycle holds only if that
// response has not been taken by then. Handles carry VERSION_BITS of
// version above INDEX_BITS of slot index, cut to 32 bits. Create pops the
// most recently freed slot, or else the next never-used one, and flags
// full when neither exists. Destroy and check accept only live handles;
// an all-ones handle is never live. There is no clearing pass after
// reset: table entries only count for slots below the used mark.
module generational_handle_allocator #(
    parameter int INDEX_BITS   = 10,
    parameter int VERSION_BITS = 22
) (
    input logic       clk,
    input logic       rst_n,
    gha_req_if.sink   req,
    gha_rsp_if.source rsp
);

    gha_pkg::ctrl_cmd_t cmd;
    gha_pkg::dp_stat_t  stat;

    // Sequence each request through read and commit
    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the tables, counters and the response register
    gha_datapath #(
        .INDEX_BITS   (INDEX_BITS),
        .VERSION_BITS (VERSION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_action (req.action),
        .req_handle (req.handle_in),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_handle (rsp.handle_out),
        .out_status (rsp.status)
    );

    assign req.ready = cmd.ready;

endmodule

FILE: rtl/gha_checker.sv
// Port-level checker for the handle allocator, bound to the top level.
`include "assert_macros.svh"

module gha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_handle,
    input logic [1:0]  rsp_status
);

    `GHA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready, "request accepted during previous request")
    `GHA_ASSERT(a_status_code, clk, rst_n, !rsp_valid || (rsp_status != 2'd3), "unused status code")
    `GHA_ASSERT(a_zero_on_fail, clk, rst_n, !rsp_valid || (rsp_status == gha_pkg::STAT_OK) || (rsp_handle == 32'd0), "failed response carries a handle")
    `GHA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_handle (rsp.handle_out),
    .rsp_status (rsp.status)
);
